// ===== rtl/tcgr_pkg.sv =====
`timescale 1ns / 1ps

package tcgr_pkg;

	localparam int GLYPH_LINES = 8;
	localparam int PIX_AW      = 18;
	localparam int COLOUR_W    = 8;

	localparam logic [7:0] INK_RESET   = 8'd7;
	localparam logic [7:0] PITCH_RESET = 8'd64;
	localparam logic [7:0] INK_BIAS    = 8'h30;

	typedef enum logic [1:0] {
		ACT_FONT   = 2'd0,
		ACT_TEXT   = 2'd1,
		ACT_CURSOR = 2'd2
	} action_t;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_BEL = 8'h07;
	localparam logic [7:0] CH_BS  = 8'h08;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_FF  = 8'h0C;

	typedef enum logic [1:0] {
		ESC_NONE = 2'd0,
		ESC_INK  = 2'd1,
		ESC_SKIP = 2'd2
	} esc_t;

	function automatic logic [7:0] flip_bits(input logic [7:0] v);
		logic [7:0] t;
		t = ((v & 8'h0f) << 4) | ((v & 8'hf0) >> 4);
		t = ((t & 8'h33) << 2) | ((t & 8'hcc) >> 2);
		t = ((t & 8'h55) << 1) | ((t & 8'haa) >> 1);
		return t;
	endfunction

endpackage

// ===== rtl/text_console_glyph_renderer.sv =====
`timescale 1ns / 1ps
// Text console renderer for 8x8 glyphs. Input items on in_valid/in_ready carry an
// action: a font row write, a text byte, or a cursor move. A printable text byte
// produces one pixel write item on out_valid/out_ready for every set bit of its
// glyph, scanline by scanline, with last marking the final pixel of the character.
// The line pitch register is written on cfg_valid/cfg_ready, which is always ready.
// Font writes, cursor moves and control bytes complete in the idle state. A printable
// character fetches its eight glyph rows from the single-port font RAM (ST_FETCH,
// then ST_LAST), then walks its pixel positions at one per cycle, pausing while
// the output is stalled, up to its last set bit; no new input item is taken
// while a character is being fetched or scanned.
// Characters with no set bits or outside the font produce no pixel items.
// After reset the font RAM is cleared one entry per cycle, all GLYPH_COUNT*8 entries,
// while in_ready stays low; the cursor returns to the top left and the ink to 7.
// When the receiver stalls, the finished pixel holds in the output register and
// the scan pauses on the next set bit; the next input item is taken once the
// last pixel of a character has entered the output register.

module text_console_glyph_renderer #(
	parameter int LAST_COLUMN = 31,
	parameter int LAST_ROW    = 31,
	parameter int GLYPH_COUNT = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [7:0]                    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    action,
	input  logic [7:0]                    code,
	input  logic [2:0]                    glyph_row,
	input  logic [7:0]                    row_bits,
	input  logic [4:0]                    new_column,
	input  logic [4:0]                    new_row,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [tcgr_pkg::PIX_AW-1:0]   pixel_address,
	output logic [tcgr_pkg::COLOUR_W-1:0] pixel_colour,
	output logic                          last
);

	import tcgr_pkg::*;

	localparam int CMAX  = (LAST_COLUMN > 31) ? LAST_COLUMN : 31;
	localparam int RMAX  = (LAST_ROW > 31) ? LAST_ROW : 31;
	localparam int CW    = $clog2(CMAX + 2);
	localparam int RW    = $clog2(RMAX + 2);
	localparam int DEPTH = GLYPH_COUNT * GLYPH_LINES;
	localparam int AW    = $clog2(DEPTH);

	logic [7:0]    pitch_q;
	logic [AW-1:0] ram_addr;
	logic          ram_we;
	logic [7:0]    ram_wdata;
	logic [7:0]    ram_rdata;
	logic          scan_busy;
	logic          scan_start;
	logic [RW-1:0] job_row;
	logic [CW-1:0] job_col;
	logic [7:0]    job_ink;
	logic [63:0]   job_mask;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_q <= PITCH_RESET;
		end else if (cfg_valid) begin
			pitch_q <= cfg_data;
		end
	end

	tcgr_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_font (
		.clk  (clk),
		.addr (ram_addr),
		.we   (ram_we),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	tcgr_ctrl #(
		.LAST_COLUMN(LAST_COLUMN),
		.LAST_ROW   (LAST_ROW),
		.GLYPH_COUNT(GLYPH_COUNT)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.code      (code),
		.glyph_row (glyph_row),
		.row_bits  (row_bits),
		.new_column(new_column),
		.new_row   (new_row),
		.ram_addr  (ram_addr),
		.ram_we    (ram_we),
		.ram_wdata (ram_wdata),
		.ram_rdata (ram_rdata),
		.scan_busy (scan_busy),
		.scan_start(scan_start),
		.job_row   (job_row),
		.job_col   (job_col),
		.job_ink   (job_ink),
		.job_mask  (job_mask)
	);

	tcgr_scan #(
		.LAST_COLUMN(LAST_COLUMN),
		.LAST_ROW   (LAST_ROW)
	) u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (scan_start),
		.job_row      (job_row),
		.job_col      (job_col),
		.job_ink      (job_ink),
		.job_mask     (job_mask),
		.pitch        (pitch_q),
		.busy         (scan_busy),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pixel_address(pixel_address),
		.pixel_colour (pixel_colour),
		.last         (last)
	);

endmodule

// ===== rtl/tcgr_ram.sv =====
`timescale 1ns / 1ps

module tcgr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic                     we,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// ===== rtl/tcgr_ctrl.sv =====
`timescale 1ns / 1ps

module tcgr_ctrl #(
	parameter int LAST_COLUMN = 31,
	parameter int LAST_ROW    = 31,
	parameter int GLYPH_COUNT = 256,
	localparam int CMAX = (LAST_COLUMN > 31) ? LAST_COLUMN : 31,
	localparam int RMAX = (LAST_ROW > 31) ? LAST_ROW : 31,
	localparam int CW   = $clog2(CMAX + 2),
	localparam int RW   = $clog2(RMAX + 2),
	localparam int AW   = $clog2(GLYPH_COUNT * 8)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [1:0]    action,
	input  logic [7:0]    code,
	input  logic [2:0]    glyph_row,
	input  logic [7:0]    row_bits,
	input  logic [4:0]    new_column,
	input  logic [4:0]    new_row,
	output logic [AW-1:0] ram_addr,
	output logic          ram_we,
	output logic [7:0]    ram_wdata,
	input  logic [7:0]    ram_rdata,
	input  logic          scan_busy,
	output logic          scan_start,
	output logic [RW-1:0] job_row,
	output logic [CW-1:0] job_col,
	output logic [7:0]    job_ink,
	output logic [63:0]   job_mask
);

	import tcgr_pkg::*;

	localparam int CIW = AW - 3;
	localparam logic [AW-1:0] CLR_LAST = AW'(GLYPH_COUNT * 8 - 1);
	localparam logic [CW-1:0] LAST_COL_C = CW'(LAST_COLUMN);
	localparam logic [CW-1:0] TAB_LIMIT = CW'(LAST_COLUMN - 7);
	localparam logic [RW-1:0] LAST_ROW_C = RW'(LAST_ROW);
	localparam logic [8:0] GLYPH_COUNT_C = 9'(GLYPH_COUNT);

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_FETCH = 4'b0100,
		ST_LAST  = 4'b1000
	} state_t;

	state_t          st_q;
	logic [AW-1:0]   clr_q;
	logic [2:0]      line_q;
	logic [CW-1:0]   col_q, col_n;
	logic [RW-1:0]   row_q, row_n;
	logic [7:0]      ink_q, ink_n;
	esc_t            esc_q, esc_n;
	logic [CIW-1:0]  job_code_q;
	logic [RW-1:0]   job_row_q;
	logic [CW-1:0]   job_col_q;
	logic [7:0]      job_ink_q;
	logic [7:0]      glyph_q [7];
	logic [7:0]      gl [8];
	logic            accept;
	logic            code_ok;
	logic            draw;
	logic            wrap;
	logic [2:0]      prev_line;

	assign in_ready = (st_q == ST_IDLE) && !scan_busy;
	assign accept   = in_valid && in_ready;
	assign code_ok  = {1'b0, code} < GLYPH_COUNT_C;
	assign prev_line = line_q - 3'd1;

	always_comb begin
		col_n = col_q;
		row_n = row_q;
		ink_n = ink_q;
		esc_n = esc_q;
		draw  = 1'b0;
		wrap  = 1'b0;
		case (action)
			ACT_TEXT: begin
				wrap = 1'b1;
				if (esc_q == ESC_INK) begin
					ink_n = code - INK_BIAS;
					esc_n = ESC_NONE;
				end else if (esc_q != ESC_NONE) begin
					esc_n = ESC_NONE;
				end else begin
					case (code)
						CH_NUL: wrap = 1'b0;
						CH_BS: begin
							if (col_q != '0) begin
								col_n = col_q - CW'(1);
							end
						end
						CH_TAB: begin
							if (col_q < TAB_LIMIT) begin
								col_n = col_q + CW'(5);
							end
						end
						CH_LF: begin
							col_n = '0;
							row_n = row_q + RW'(1);
						end
						CH_FF: esc_n = ESC_INK;
						CH_BEL: esc_n = ESC_SKIP;
						default: begin
							draw  = 1'b1;
							col_n = col_q + CW'(1);
						end
					endcase
				end
				if (wrap) begin
					if (col_n > LAST_COL_C) begin
						col_n = '0;
						row_n = row_n + RW'(1);
					end
					if (row_n > LAST_ROW_C) begin
						row_n = '0;
					end
				end
			end
			ACT_CURSOR: begin
				col_n = CW'(new_column);
				row_n = RW'(new_row);
			end
			default: ;
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = {job_code_q, line_q};
		ram_wdata = '0;
		case (st_q)
			ST_CLEAR: begin
				ram_we   = 1'b1;
				ram_addr = clr_q;
			end
			ST_IDLE: begin
				ram_we    = accept && (action == ACT_FONT) && code_ok;
				ram_addr  = {code[CIW-1:0], glyph_row};
				ram_wdata = flip_bits(row_bits);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_CLEAR;
			clr_q  <= '0;
			line_q <= '0;
			col_q  <= '0;
			row_q  <= '0;
			ink_q  <= INK_RESET;
			esc_q  <= ESC_NONE;
		end else begin
			case (st_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == CLR_LAST) begin
						st_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						col_q <= col_n;
						row_q <= row_n;
						ink_q <= ink_n;
						esc_q <= esc_n;
						if (draw && code_ok) begin
							line_q <= '0;
							st_q   <= ST_FETCH;
						end
					end
				end
				ST_FETCH: begin
					line_q <= line_q + 3'd1;
					if (line_q == 3'd7) begin
						st_q <= ST_LAST;
					end
				end
				ST_LAST: st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			job_code_q <= code[CIW-1:0];
			job_row_q  <= row_q;
			job_col_q  <= col_q;
			job_ink_q  <= ink_q;
		end
		if (st_q == ST_FETCH && line_q != 3'd0) begin
			glyph_q[prev_line] <= ram_rdata;
		end
	end

	always_comb begin
		for (int l = 0; l < 7; l++) begin
			gl[l] = glyph_q[l];
		end
		gl[7] = ram_rdata;
		for (int l = 0; l < 8; l++) begin
			for (int b = 0; b < 8; b++) begin
				job_mask[l*8+b] = gl[l][7-b];
			end
		end
	end

	assign scan_start = (st_q == ST_LAST);
	assign job_row    = job_row_q;
	assign job_col    = job_col_q;
	assign job_ink    = job_ink_q;

endmodule

// ===== rtl/tcgr_scan.sv =====
`timescale 1ns / 1ps

module tcgr_scan #(
	parameter int LAST_COLUMN = 31,
	parameter int LAST_ROW    = 31,
	localparam int CMAX = (LAST_COLUMN > 31) ? LAST_COLUMN : 31,
	localparam int RMAX = (LAST_ROW > 31) ? LAST_ROW : 31,
	localparam int CW   = $clog2(CMAX + 2),
	localparam int RW   = $clog2(RMAX + 2)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [RW-1:0]                   job_row,
	input  logic [CW-1:0]                   job_col,
	input  logic [7:0]                      job_ink,
	input  logic [63:0]                     job_mask,
	input  logic [7:0]                      pitch,
	output logic                            busy,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [tcgr_pkg::PIX_AW-1:0]     pixel_address,
	output logic [tcgr_pkg::COLOUR_W-1:0]   pixel_colour,
	output logic                            last
);

	import tcgr_pkg::*;

	localparam int PW = RW + 11;
	localparam int SW = RW + 14;

	logic                busy_q;
	logic [63:0]         mask_q;
	logic [5:0]          pos_q;
	logic                ov_q;
	logic [PIX_AW-1:0]   addr_q;
	logic [COLOUR_W-1:0] colour_q;
	logic                last_q;
	logic                can_load;
	logic                step;
	logic                emit;
	logic                fin;
	logic [RW+2:0]       line_idx;
	logic [PW-1:0]       prod;
	logic [SW-1:0]       addr_full;

	assign can_load = !ov_q || out_ready;
	assign step     = busy_q && (!mask_q[0] || can_load);
	assign emit     = busy_q && mask_q[0] && can_load;
	assign fin      = (mask_q[63:1] == '0);

	assign line_idx  = {job_row, pos_q[5:3]};
	assign prod      = PW'(line_idx) * PW'(pitch);
	assign addr_full = {prod, 3'b000} + SW'({job_col, pos_q[2:0]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ov_q   <= 1'b0;
		end else begin
			if (start) begin
				busy_q <= (job_mask != '0);
			end else if (emit && fin) begin
				busy_q <= 1'b0;
			end
			if (can_load) begin
				ov_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mask_q <= job_mask;
			pos_q  <= '0;
		end else if (step) begin
			mask_q <= mask_q >> 1;
			pos_q  <= pos_q + 6'd1;
		end
		if (emit) begin
			addr_q   <= addr_full[PIX_AW-1:0];
			colour_q <= job_ink;
			last_q   <= fin;
		end
	end

	assign busy          = busy_q;
	assign out_valid     = ov_q;
	assign pixel_address = addr_q;
	assign pixel_colour  = colour_q;
	assign last          = last_q;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import tcgr_pkg::*;

	localparam int LAST_COLUMN  = 31;
	localparam int LAST_ROW     = 31;
	localparam int GLYPH_COUNT  = 256;
	localparam int STALL_LIMIT  = 10000;
	localparam int DRAIN_CYCLES = 200;
	localparam int REPORT_MAX   = 10;
	localparam int PHASE_ITEMS  = 38;

	localparam logic [1:0] ACT_NONE   = 2'd3;
	localparam logic [7:0] GLYPH_BASE = 8'h41;
	localparam logic [7:0] GLYPH_TOP  = 8'hFF;
	localparam logic [7:0] DIGIT_NINE = 8'h39;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] code;
		logic [2:0] glyph_row;
		logic [7:0] row_bits;
		logic [4:0] new_column;
		logic [4:0] new_row;
	} console_item_t;

	typedef struct packed {
		logic [PIX_AW-1:0]   address;
		logic [COLOUR_W-1:0] colour;
		logic                last;
	} pixel_write_t;

	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                cfg_valid  = 1'b0;
	logic                cfg_ready;
	logic [7:0]          cfg_data   = PITCH_RESET;
	logic                in_valid   = 1'b0;
	logic                in_ready;
	logic [1:0]          action     = ACT_FONT;
	logic [7:0]          code       = CH_NUL;
	logic [2:0]          glyph_row  = 3'd0;
	logic [7:0]          row_bits   = 8'd0;
	logic [4:0]          new_column = 5'd0;
	logic [4:0]          new_row    = 5'd0;
	logic                out_valid;
	logic                out_ready  = 1'b0;
	logic [PIX_AW-1:0]   pixel_address;
	logic [COLOUR_W-1:0] pixel_colour;
	logic                last;

	text_console_glyph_renderer #(
		.LAST_COLUMN(LAST_COLUMN),
		.LAST_ROW   (LAST_ROW),
		.GLYPH_COUNT(GLYPH_COUNT)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.code         (code),
		.glyph_row    (glyph_row),
		.row_bits     (row_bits),
		.new_column   (new_column),
		.new_row      (new_row),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pixel_address(pixel_address),
		.pixel_colour (pixel_colour),
		.last         (last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	console_item_t item_queue[$];
	pixel_write_t  pixel_queue[$];
	console_item_t in_flight;

	logic [7:0] font_rom [0:GLYPH_COUNT*GLYPH_LINES-1];
	int         cur_col;
	int         cur_row;
	int         pitch;
	logic [7:0] ink;
	esc_t       esc_state;

	int in_gap         = 0;
	int ready_hold     = 0;
	int errors         = 0;
	int idle_cycles    = 0;
	int items_queued   = 0;
	int items_accepted = 0;
	bit no_gaps        = 1'b0;
	bit next_valid;

	function automatic int pick_gap();
		int r;
		if (no_gaps) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 65) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] reverse_byte(input logic [7:0] v);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[i] = v[7-i];
		end
		return r;
	endfunction

	task automatic render_glyph(input logic [7:0] ch);
		pixel_write_t held;
		pixel_write_t px;
		bit           have_held;
		int           a;
		have_held = 1'b0;
		held = '0;
		for (int line = 0; line < GLYPH_LINES; line++) begin
			for (int b = 0; b < 8; b++) begin
				if (font_rom[int'(ch) * GLYPH_LINES + line][7-b]) begin
					a = (cur_row * GLYPH_LINES + line) * pitch * 8 + cur_col * 8 + b;
					px.address = a[PIX_AW-1:0];
					px.colour = ink;
					px.last = 1'b0;
					if (have_held) begin
						pixel_queue.push_back(held);
					end
					held = px;
					have_held = 1'b1;
				end
			end
		end
		if (have_held) begin
			held.last = 1'b1;
			pixel_queue.push_back(held);
		end
	endtask

	task automatic apply_text(input logic [7:0] c);
		if (esc_state == ESC_INK) begin
			ink = c - INK_BIAS;
			esc_state = ESC_NONE;
		end else if (esc_state != ESC_NONE) begin
			esc_state = ESC_NONE;
		end else if (c == CH_NUL) begin
			return;
		end else if (c == CH_BS) begin
			if (cur_col > 0) begin
				cur_col--;
			end
		end else if (c == CH_TAB) begin
			if (cur_col < LAST_COLUMN - 7) begin
				cur_col += 5;
			end
		end else if (c == CH_LF) begin
			cur_col = 0;
			cur_row++;
		end else if (c == CH_FF) begin
			esc_state = ESC_INK;
		end else if (c == CH_BEL) begin
			esc_state = ESC_SKIP;
		end else begin
			render_glyph(c);
			cur_col++;
		end
		if (cur_col > LAST_COLUMN) begin
			cur_col = 0;
			cur_row++;
		end
		if (cur_row > LAST_ROW) begin
			cur_row = 0;
		end
	endtask

	task automatic predict_item(input console_item_t it);
		case (it.action)
			ACT_FONT: begin
				font_rom[int'(it.code) * GLYPH_LINES + int'(it.glyph_row)] =
					reverse_byte(it.row_bits);
			end
			ACT_TEXT: begin
				apply_text(it.code);
			end
			ACT_CURSOR: begin
				cur_col = int'(it.new_column);
				cur_row = int'(it.new_row);
			end
			default: begin
			end
		endcase
	endtask

	task automatic enqueue(input console_item_t it);
		item_queue.push_back(it);
		items_queued++;
	endtask

	task automatic push_item(input logic [1:0] act, input logic [7:0] c,
			input logic [2:0] g, input logic [7:0] b,
			input logic [4:0] col, input logic [4:0] row);
		console_item_t it;
		it.action = act;
		it.code = c;
		it.glyph_row = g;
		it.row_bits = b;
		it.new_column = col;
		it.new_row = row;
		enqueue(it);
	endtask

	function automatic console_item_t random_item();
		logic [31:0] raw;
		raw = $urandom;
		return raw[$bits(console_item_t)-1:0];
	endfunction

	// Most items build up a small set of glyphs and draw them, so that
	// characters produce dense pixel bursts; the rest is control and noise.
	task automatic push_random();
		console_item_t it;
		int            r;
		it = random_item();
		r = $urandom_range(0, 99);
		if (r < 15) begin
			it.action = ACT_FONT;
			if ($urandom_range(0, 3) != 0) begin
				it.code = GLYPH_BASE + 8'($urandom_range(0, 7));
			end
			enqueue(it);
		end else if (r < 65) begin
			it.action = ACT_TEXT;
			if ($urandom_range(0, 9) < 7) begin
				it.code = GLYPH_BASE + 8'($urandom_range(0, 7));
			end
			enqueue(it);
		end else if (r < 75) begin
			it.action = ACT_TEXT;
			case ($urandom_range(0, 3))
				0: it.code = CH_BS;
				1: it.code = CH_TAB;
				2: it.code = CH_LF;
				default: it.code = CH_NUL;
			endcase
			enqueue(it);
		end else if (r < 85) begin
			it.action = ACT_TEXT;
			it.code = ($urandom_range(0, 1) != 0) ? CH_FF : CH_BEL;
			enqueue(it);
			it = random_item();
			it.action = ACT_TEXT;
			if ($urandom_range(0, 1) != 0) begin
				it.code = INK_BIAS + 8'($urandom_range(0, 15));
			end
			enqueue(it);
		end else if (r < 97) begin
			it.action = ACT_CURSOR;
			enqueue(it);
		end else begin
			it.action = ACT_NONE;
			enqueue(it);
		end
	endtask

	task automatic settle();
		while (items_accepted != items_queued || pixel_queue.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_pitch(input logic [7:0] v);
		@(posedge clk);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		cfg_valid <= 1'b0;
		pitch = int'(v);
	endtask

	task automatic note_mismatch(input pixel_write_t want);
		errors++;
		if (errors <= REPORT_MAX) begin
			$display("pixel mismatch: expected addr=%h colour=%h last=%b, got addr=%h colour=%h last=%b",
				want.address, want.colour, want.last, pixel_address, pixel_colour, last);
		end
	endtask

	always @(posedge clk) begin
		next_valid = in_valid;
		if (in_valid && in_ready) begin
			predict_item(in_flight);
			items_accepted++;
			next_valid = 1'b0;
		end
		if (!next_valid && arst_n) begin
			if (in_gap > 0) begin
				in_gap--;
			end else if (item_queue.size() != 0) begin
				in_flight = item_queue.pop_front();
				action <= in_flight.action;
				code <= in_flight.code;
				glyph_row <= in_flight.glyph_row;
				row_bits <= in_flight.row_bits;
				new_column <= in_flight.new_column;
				new_row <= in_flight.new_row;
				next_valid = 1'b1;
				in_gap = pick_gap();
			end
		end
		in_valid <= next_valid;
	end

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (pixel_queue.size() == 0) begin
				note_mismatch('0);
			end else if (pixel_queue[0].address !== pixel_address
					|| pixel_queue[0].colour !== pixel_colour
					|| pixel_queue[0].last !== last) begin
				note_mismatch(pixel_queue.pop_front());
			end else begin
				void'(pixel_queue.pop_front());
			end
		end
		if (ready_hold > 0) begin
			ready_hold--;
			out_ready <= 1'b0;
		end else begin
			ready_hold = ($urandom_range(0, 3) != 0) ? 0 : pick_gap();
			out_ready <= (ready_hold == 0);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		logic [7:0] pitches [0:5];
		int         target;
		for (int i = 0; i < GLYPH_COUNT * GLYPH_LINES; i++) begin
			font_rom[i] = 8'd0;
		end
		cur_col = 0;
		cur_row = 0;
		pitch = int'(PITCH_RESET);
		ink = INK_RESET;
		esc_state = ESC_NONE;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		push_item(ACT_TEXT, GLYPH_BASE, 3'd0, 8'h00, 5'd0, 5'd0);
		push_item(ACT_FONT, GLYPH_BASE, 3'd0, 8'hFF, 5'd0, 5'd0);
		push_item(ACT_FONT, GLYPH_BASE, 3'd1, 8'h81, 5'd0, 5'd0);
		push_item(ACT_FONT, GLYPH_BASE, 3'd2, 8'h01, 5'd0, 5'd0);
		push_item(ACT_FONT, GLYPH_BASE, 3'd3, 8'h80, 5'd0, 5'd0);
		push_item(ACT_FONT, GLYPH_BASE, 3'd4, 8'h00, 5'd0, 5'd0);
		push_item(ACT_FONT, GLYPH_BASE, 3'd5, 8'h3C, 5'd0, 5'd0);
		push_item(ACT_FONT, GLYPH_BASE, 3'd6, 8'hAA, 5'd0, 5'd0);
		push_item(ACT_FONT, GLYPH_BASE, 3'd7, 8'h55, 5'd0, 5'd0);
		push_item(ACT_FONT, GLYPH_TOP, 3'd7, 8'hFF, 5'd31, 5'd31);
		push_item(ACT_FONT, CH_NUL, 3'd0, 8'h5A, 5'd0, 5'd0);
		push_item(ACT_TEXT, GLYPH_BASE, 3'd0, 8'h00, 5'd0, 5'd0);
		push_item(ACT_CURSOR, CH_NUL, 3'd0, 8'h00, 5'd31, 5'd31);
		push_item(ACT_TEXT, GLYPH_TOP, 3'd7, 8'hFF, 5'd0, 5'd0);
		push_item(ACT_TEXT, CH_BS, 3'd0, 8'h00, 5'd0, 5'd0);
		push_item(ACT_CURSOR, CH_NUL, 3'd0, 8'h00, 5'd24, 5'd0);
		push_item(ACT_TEXT, CH_TAB, 3'd0, 8'h00, 5'd0, 5'd0);
		push_item(ACT_CURSOR, CH_NUL, 3'd0, 8'h00, 5'd23, 5'd5);
		push_item(ACT_TEXT, CH_TAB, 3'd0, 8'h00, 5'd0, 5'd0);
		push_item(ACT_TEXT, CH_LF, 3'd0, 8'h00, 5'd0, 5'd0);
		push_item(ACT_TEXT, CH_FF, 3'd0, 8'h00, 5'd0, 5'd0);
		push_item(ACT_TEXT, CH_NUL, 3'd0, 8'h00, 5'd0, 5'd0);
		push_item(ACT_TEXT, CH_BEL, 3'd0, 8'h00, 5'd0, 5'd0);
		push_item(ACT_TEXT, CH_LF, 3'd0, 8'h00, 5'd0, 5'd0);
		push_item(ACT_TEXT, CH_NUL, 3'd0, 8'h00, 5'd0, 5'd0);
		push_item(ACT_NONE, GLYPH_BASE, 3'd0, 8'h00, 5'd0, 5'd0);
		push_item(ACT_TEXT, GLYPH_BASE, 3'd0, 8'h00, 5'd0, 5'd0);
		push_item(ACT_TEXT, CH_FF, 3'd0, 8'h00, 5'd0, 5'd0);
		push_item(ACT_TEXT, DIGIT_NINE, 3'd0, 8'h00, 5'd0, 5'd0);
		settle();

		pitches[0] = 8'd1;
		pitches[1] = 8'd128;
		pitches[2] = 8'd0;
		pitches[3] = 8'd255;
		pitches[4] = 8'($urandom_range(1, 128));
		pitches[5] = 8'($urandom_range(1, 128));
		for (int p = 0; p < 6; p++) begin
			no_gaps = (p == 2);
			set_pitch(pitches[p]);
			target = items_queued + PHASE_ITEMS;
			while (items_queued < target) begin
				push_random();
			end
			settle();
		end

		if (errors == 0 && pixel_queue.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/tcgr_pkg.sv
rtl/tcgr_ram.sv
rtl/tcgr_ctrl.sv
rtl/tcgr_scan.sv
rtl/text_console_glyph_renderer.sv
sim/testbench.sv
